// ----- rtl/sam_pkg.sv -----
package sam_pkg;

  localparam int MaxChars  = 256;
  localparam int Alphabet  = 256;
  localparam int MaxNodes  = 512;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CharW     = $clog2(Alphabet);
  localparam int LenW      = $clog2(MaxChars + 1);
  localparam int CntW      = 9;
  localparam int TrW       = NodeW + CharW;
  localparam int TrDepth   = MaxNodes * Alphabet;
  localparam int NodeRowW  = LenW + NodeW + CntW;
  localparam logic [CntW-1:0] OccMax = '1;

  typedef enum logic [1:0] {
    REQ_EXTEND   = 2'd0,
    REQ_FINALIZE = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_X_RDLAST,
    ST_X_WRCUR,
    ST_X_RDP,
    ST_X_CHKP,
    ST_X_RDQ,
    ST_X_CHKQ,
    ST_X_CPRD,
    ST_X_CPWR,
    ST_X_RD2,
    ST_X_CHK2,
    ST_X_FIX,
    ST_F_RD,
    ST_F_CHK,
    ST_F_RDT,
    ST_F_WRT,
    ST_Q_RD,
    ST_Q_DONE,
    ST_OUT
  } state_t;

  // node row packing: len | link | occ
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [NodeW-1:0] link;
    logic [CntW-1:0]  occ;
  } node_row_t;

endpackage

// ----- rtl/sam_ram.sv -----
module sam_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/suffix_automaton_occurrence_count_core.sv -----
// Suffix automaton with substring occurrence counts. Extend (req 0) appends a
// corpus byte, finalize (req 1) propagates counts, query (req 2) walks one
// pattern byte and the byte with last_char set returns the count, clear (req 3)
// empties the automaton. One item is handled at a time. Node rows and the
// transition table sit in single-port-read RAMs with registered reads;
// transition entries carry a valid bit cleared by a sweep. After reset and
// after every clear the block sweeps all MaxNodes*Alphabet transition entries,
// one per cycle, before taking an item. A query byte reads its transition and
// then the target node row. An extend visits suffix links until it finds an
// existing transition or passes the root, reads that target, and when a clone
// is made copies all Alphabet transition entries of the target and then
// redirects links to the clone. A dropped extend returns its result with status
// set. Finalize scans every non-root node once per length.
module suffix_automaton_occurrence_count_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [7:0]                 in_char_code,
  input  logic                       in_last_char,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sam_pkg::CntW-1:0]   out_count,
  output logic                       out_status
);

  localparam int NW = sam_pkg::NodeW;
  localparam int CW = sam_pkg::CharW;
  localparam int LW = sam_pkg::LenW;
  localparam int TW = sam_pkg::TrW;

  sam_pkg::state_t state_r, state_nxt;

  // node RAM
  logic                  nd_we;
  logic [NW-1:0]         nd_waddr, nd_raddr;
  sam_pkg::node_row_t    nd_wdata, nd_rdata;
  // transition RAM: valid | target
  logic                  tr_we;
  logic [TW-1:0]         tr_waddr, tr_raddr;
  logic [NW:0]           tr_wdata, tr_rdata;

  sam_ram #(.Width(sam_pkg::NodeRowW), .Depth(sam_pkg::MaxNodes)) u_node_ram (
    .clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata), .raddr(nd_raddr),
    .rdata(nd_rdata)
  );

  sam_ram #(.Width(NW + 1), .Depth(sam_pkg::TrDepth)) u_tr_ram (
    .clk, .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata), .raddr(tr_raddr),
    .rdata(tr_rdata)
  );

  logic [NW:0]     node_count_r, node_count_nxt;
  logic [NW-1:0]   last_node_r, last_node_nxt;
  logic [NW-1:0]   qcur_r, qcur_nxt;
  logic            qdead_r, qdead_nxt;
  logic [TW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   ch_r, ch_nxt;
  logic            lastc_r, lastc_nxt;
  logic [NW-1:0]   cur_r, cur_nxt;
  logic [NW-1:0]   p_r, p_nxt;
  logic [LW-1:0]   plen_r, plen_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [NW-1:0]   cl_r, cl_nxt;
  logic [CW:0]     cp_r, cp_nxt;
  logic [LW-1:0]   flen_r, flen_nxt;
  logic [NW:0]     fi_r, fi_nxt;
  logic [NW-1:0]   ft_r, ft_nxt;
  logic [sam_pkg::CntW-1:0] focc_r, focc_nxt;
  logic [sam_pkg::CntW-1:0] ocnt_r, ocnt_nxt;
  logic            ostat_r, ostat_nxt;
  logic [LW-1:0]   lastlen_r, lastlen_nxt;

  logic            accept;
  logic [sam_pkg::CntW:0] occ_sum;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != sam_pkg::ST_IDLE);
  assign out_valid = (state_r == sam_pkg::ST_OUT);
  assign out_count = ocnt_r;
  assign out_status = ostat_r;
  assign occ_sum = {1'b0, focc_r} + {1'b0, nd_rdata.occ};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sam_pkg::ST_CLEAR: begin
        if (clr_r == TW'(sam_pkg::TrDepth - 1)) state_nxt = sam_pkg::ST_IDLE;
      end
      sam_pkg::ST_IDLE: begin
        if (accept) begin
          case (sam_pkg::req_t'(in_req_type))
            sam_pkg::REQ_EXTEND:   state_nxt = sam_pkg::ST_X_RDLAST;
            sam_pkg::REQ_FINALIZE: state_nxt = sam_pkg::ST_F_RD;
            sam_pkg::REQ_QUERY:    state_nxt = sam_pkg::ST_Q_RD;
            default:               state_nxt = sam_pkg::ST_CLEAR;
          endcase
        end
      end
      sam_pkg::ST_X_RDLAST: begin
        if (node_count_r > (NW+1)'(sam_pkg::MaxNodes - 2) ||
            nd_rdata.len >= LW'(sam_pkg::MaxChars)) begin
          state_nxt = sam_pkg::ST_OUT;
        end else begin
          state_nxt = sam_pkg::ST_X_WRCUR;
        end
      end
      sam_pkg::ST_X_WRCUR: state_nxt = sam_pkg::ST_X_RDP;
      sam_pkg::ST_X_RDP:   state_nxt = sam_pkg::ST_X_CHKP;
      sam_pkg::ST_X_CHKP: begin
        if (!tr_rdata[NW]) begin
          state_nxt = (p_r == '0) ? sam_pkg::ST_IDLE : sam_pkg::ST_X_RDP;
        end else begin
          state_nxt = sam_pkg::ST_X_RDQ;
        end
      end
      sam_pkg::ST_X_RDQ: state_nxt = sam_pkg::ST_X_CHKQ;
      sam_pkg::ST_X_CHKQ: begin
        state_nxt = (plen_r + 1'b1 == nd_rdata.len) ? sam_pkg::ST_IDLE :
                    sam_pkg::ST_X_CPRD;
      end
      sam_pkg::ST_X_CPRD: state_nxt = sam_pkg::ST_X_CPWR;
      sam_pkg::ST_X_CPWR: begin
        state_nxt = (cp_r == (CW+1)'(sam_pkg::Alphabet - 1)) ? sam_pkg::ST_X_RD2 :
                    sam_pkg::ST_X_CPRD;
      end
      sam_pkg::ST_X_RD2: state_nxt = sam_pkg::ST_X_CHK2;
      sam_pkg::ST_X_CHK2: begin
        if (tr_rdata[NW] && tr_rdata[NW-1:0] == q_r && p_r != '0) begin
          state_nxt = sam_pkg::ST_X_RD2;
        end else begin
          state_nxt = sam_pkg::ST_X_FIX;
        end
      end
      sam_pkg::ST_X_FIX: state_nxt = sam_pkg::ST_IDLE;
      sam_pkg::ST_F_RD: begin
        if (flen_r == '0) state_nxt = sam_pkg::ST_IDLE;
        else if (fi_r >= node_count_r) state_nxt = sam_pkg::ST_F_RD;
        else state_nxt = sam_pkg::ST_F_CHK;
      end
      sam_pkg::ST_F_CHK: begin
        state_nxt = (nd_rdata.len == flen_r) ? sam_pkg::ST_F_RDT : sam_pkg::ST_F_RD;
      end
      sam_pkg::ST_F_RDT: state_nxt = sam_pkg::ST_F_WRT;
      sam_pkg::ST_F_WRT: state_nxt = sam_pkg::ST_F_RD;
      sam_pkg::ST_Q_RD:  state_nxt = sam_pkg::ST_Q_DONE;
      sam_pkg::ST_Q_DONE: state_nxt = lastc_r ? sam_pkg::ST_OUT : sam_pkg::ST_IDLE;
      sam_pkg::ST_OUT: if (!out_stall) state_nxt = sam_pkg::ST_IDLE;
      default: state_nxt = sam_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_raddr = '0;
    tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0; tr_raddr = '0;
    node_count_nxt = node_count_r; last_node_nxt = last_node_r;
    qcur_nxt = qcur_r; qdead_nxt = qdead_r; clr_nxt = clr_r;
    ch_nxt = ch_r; lastc_nxt = lastc_r; cur_nxt = cur_r; p_nxt = p_r;
    plen_nxt = plen_r; q_nxt = q_r; cl_nxt = cl_r;
    cp_nxt = cp_r; flen_nxt = flen_r; fi_nxt = fi_r; ft_nxt = ft_r;
    focc_nxt = focc_r; ocnt_nxt = ocnt_r; ostat_nxt = ostat_r;
    lastlen_nxt = lastlen_r;
    case (state_r)
      sam_pkg::ST_CLEAR: begin
        tr_we = 1'b1; tr_waddr = clr_r; tr_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        // root row back to zero length, no link, zero count
        nd_we = 1'b1; nd_waddr = '0;
      end
      sam_pkg::ST_IDLE: begin
        ch_nxt = in_char_code;
        lastc_nxt = in_last_char;
        nd_raddr = last_node_r;
        tr_raddr = {qcur_r, in_char_code};
        if (accept) begin
          case (sam_pkg::req_t'(in_req_type))
            sam_pkg::REQ_FINALIZE: begin
              flen_nxt = LW'(sam_pkg::MaxChars);
              fi_nxt = (NW+1)'(1);
            end
            sam_pkg::REQ_CLEAR: begin
              clr_nxt = '0;
              node_count_nxt = (NW+1)'(1);
              last_node_nxt = '0; qcur_nxt = '0; qdead_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      sam_pkg::ST_X_RDLAST: begin
        lastlen_nxt = nd_rdata.len;
        ocnt_nxt = '0; ostat_nxt = 1'b1;
        cur_nxt = node_count_r[NW-1:0];
        p_nxt = last_node_r;
      end
      sam_pkg::ST_X_WRCUR: begin
        // new node with link to root until resolved
        nd_we = 1'b1; nd_waddr = cur_r;
        nd_wdata.len = lastlen_r + 1'b1; nd_wdata.link = '0;
        nd_wdata.occ = sam_pkg::CntW'(1);
        node_count_nxt = node_count_r + 1'b1;
        last_node_nxt = cur_r;
      end
      sam_pkg::ST_X_RDP: begin
        tr_raddr = {p_r, ch_r};
        nd_raddr = p_r;
      end
      sam_pkg::ST_X_CHKP: begin
        plen_nxt = nd_rdata.len;
        if (!tr_rdata[NW]) begin
          tr_we = 1'b1; tr_waddr = {p_r, ch_r}; tr_wdata = {1'b1, cur_r};
          p_nxt = nd_rdata.link;
        end else begin
          q_nxt = tr_rdata[NW-1:0];
        end
      end
      sam_pkg::ST_X_RDQ: nd_raddr = q_r;
      sam_pkg::ST_X_CHKQ: begin
        cl_nxt = node_count_r[NW-1:0];
        cp_nxt = '0;
        if (plen_r + 1'b1 == nd_rdata.len) begin
          nd_we = 1'b1; nd_waddr = cur_r;
          nd_wdata.len = lastlen_r + 1'b1; nd_wdata.link = q_r;
          nd_wdata.occ = sam_pkg::CntW'(1);
        end else begin
          nd_we = 1'b1; nd_waddr = node_count_r[NW-1:0];
          nd_wdata.len = plen_r + 1'b1; nd_wdata.link = nd_rdata.link;
          nd_wdata.occ = '0;
          node_count_nxt = node_count_r + 1'b1;
        end
      end
      sam_pkg::ST_X_CPRD: begin
        tr_raddr = {q_r, cp_r[CW-1:0]};
        // node RAM is free during the row copy: link cur to the clone
        nd_we = 1'b1; nd_waddr = cur_r;
        nd_wdata.len = lastlen_r + 1'b1; nd_wdata.link = cl_r;
        nd_wdata.occ = sam_pkg::CntW'(1);
      end
      sam_pkg::ST_X_CPWR: begin
        tr_we = 1'b1; tr_waddr = {cl_r, cp_r[CW-1:0]}; tr_wdata = tr_rdata;
        cp_nxt = cp_r + 1'b1;
      end
      sam_pkg::ST_X_RD2: begin
        tr_raddr = {p_r, ch_r};
        nd_raddr = p_r;
      end
      sam_pkg::ST_X_CHK2: begin
        if (tr_rdata[NW] && tr_rdata[NW-1:0] == q_r) begin
          tr_we = 1'b1; tr_waddr = {p_r, ch_r}; tr_wdata = {1'b1, cl_r};
          p_nxt = nd_rdata.link;
        end
        nd_raddr = q_r;
      end
      sam_pkg::ST_X_FIX: begin
        // relink q to the clone
        nd_we = 1'b1; nd_waddr = q_r;
        nd_wdata = nd_rdata; nd_wdata.link = cl_r;
      end
      sam_pkg::ST_F_RD: begin
        nd_raddr = fi_r[NW-1:0];
        if (fi_r >= node_count_r) begin
          fi_nxt = (NW+1)'(1);
          flen_nxt = flen_r - 1'b1;
        end
      end
      sam_pkg::ST_F_CHK: begin
        ft_nxt = nd_rdata.link;
        focc_nxt = nd_rdata.occ;
        nd_raddr = nd_rdata.link;
        if (nd_rdata.len != flen_r) fi_nxt = fi_r + 1'b1;
      end
      sam_pkg::ST_F_RDT: nd_raddr = ft_r;
      sam_pkg::ST_F_WRT: begin
        nd_we = 1'b1; nd_waddr = ft_r; nd_wdata = nd_rdata;
        nd_wdata.occ = occ_sum[sam_pkg::CntW] ? sam_pkg::OccMax :
                       occ_sum[sam_pkg::CntW-1:0];
        fi_nxt = fi_r + 1'b1;
      end
      sam_pkg::ST_Q_RD: begin
        nd_raddr = tr_rdata[NW-1:0];
        if (!qdead_r) begin
          if (!tr_rdata[NW]) qdead_nxt = 1'b1;
          else qcur_nxt = tr_rdata[NW-1:0];
        end
      end
      sam_pkg::ST_Q_DONE: begin
        ocnt_nxt = qdead_r ? '0 : nd_rdata.occ;
        ostat_nxt = 1'b0;
        if (lastc_r) begin
          qcur_nxt = '0; qdead_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sam_pkg::ST_CLEAR;
      clr_r <= '0;
      node_count_r <= (NW+1)'(1);
      last_node_r <= '0;
      qcur_r <= '0;
      qdead_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      node_count_r <= node_count_nxt;
      last_node_r <= last_node_nxt;
      qcur_r <= qcur_nxt;
      qdead_r <= qdead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt; lastc_r <= lastc_nxt; cur_r <= cur_nxt; p_r <= p_nxt;
    plen_r <= plen_nxt; q_r <= q_nxt; cl_r <= cl_nxt;
    cp_r <= cp_nxt; flen_r <= flen_nxt; fi_r <= fi_nxt; ft_r <= ft_nxt;
    focc_r <= focc_nxt; ocnt_r <= ocnt_nxt; ostat_r <= ostat_nxt;
    lastlen_r <= lastlen_nxt;
  end

endmodule
